### rtl/core/lll_pkg.sv
// Package for the lease lock table: request and status codes, the
// sequencer state type and the default table depth. No dependencies.
`default_nettype none

package lll_pkg;

  localparam int ENTRIES_DEF = 32;

  // Request codes
  localparam logic [2:0] REQ_LOCK    = 3'd0;
  localparam logic [2:0] REQ_UNLOCK  = 3'd1;
  localparam logic [2:0] REQ_QUERY   = 3'd2;
  localparam logic [2:0] REQ_RELEASE = 3'd3;
  localparam logic [2:0] REQ_TICK    = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_HELD     = 2'd1;
  localparam logic [1:0] ST_BADADDR  = 2'd2;
  localparam logic [1:0] ST_RELEASED = 2'd3;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_SWEEP
  } state_t;

endpackage

`default_nettype wire

### rtl/core/lease_lock_table.sv
// Lease lock table top level: entry memory, request sequencer and result register.
// Depends on lll_pkg for codes, the state type and the default depth.
`default_nettype none

// Channel    Direction  Handshake          Beat contents
// ---------  ---------  -----------------  ------------------------------------------
// request    in         in_valid/in_stall   req_type, address, session, lease_ticks
// result     out        out_valid/out_stall status, entry_address, owner, last
// config     in         cfg_we              cfg_wdata -> active_entries
//
// Lock, unlock and query read the entry, then decide and write back. A release or
// tick sweep visits min(active_entries, ENTRIES) entries, then issues the done beat;
// it streams one entry per cycle, unless an output stall holds a release beat, through
// the single-port-read entry memory, reading the next entry while the current one is
// written back. After reset a clearing pass zeroes every entry; no request is taken
// meanwhile. Output stalls hold the sequencer only when a result beat must be issued.
module lease_lock_table
  import lll_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [5:0]  cfg_wdata,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  req_type,
  input  wire logic [5:0]  address,
  input  wire logic [15:0] session,
  input  wire logic [15:0] lease_ticks,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [5:0]       entry_address,
  output logic [15:0]      owner,
  output logic             last
);

  // IW indexes the memory; CW also holds the entry count itself and any 6-bit address.
  localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CWE = $clog2(ENTRIES + 1);
  localparam int CW  = (CWE > 7) ? CWE : 7;

  // Entry memory: owner in the upper half, lease in the lower half
  logic [31:0]   mem [ENTRIES];
  logic [31:0]   rdata;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [31:0]   mem_wd;
  logic          mem_re;
  logic [IW-1:0] mem_ra;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata <= mem[mem_ra];
    end
  end

  // Control state
  state_t        state, state_next;
  logic [CW-1:0] ptr, ptr_next;         // clear address, then sweep read pointer
  logic          d_valid, d_valid_next; // rdata holds the sweep entry at d_idx
  logic [IW-1:0] d_idx, d_idx_next;
  logic [5:0]    active_entries;

  // Latched request
  logic [2:0]    r_req;
  logic [5:0]    r_addr;
  logic [15:0]   r_sess;
  logic [15:0]   r_lease;
  logic          r_bad;

  // Effective limit: min(active_entries, ENTRIES)
  logic [CW-1:0] lim;
  assign lim = (CW'(active_entries) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(active_entries);

  logic          in_accept;
  logic          addr_bad;
  logic [IW-1:0] acc_idx;
  logic          is_sweep;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign addr_bad  = (address == 6'd0) || (CW'(address) > lim);
  assign acc_idx   = IW'(CW'(address) - CW'(1));
  assign is_sweep  = (req_type == REQ_RELEASE) || (req_type == REQ_TICK);

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // Entry fields out of the read register
  logic [15:0] d_owner, d_lease;
  assign d_owner = rdata[31:16];
  assign d_lease = rdata[15:0];

  // Sweep update of the entry in rdata
  logic [15:0] sw_owner, sw_lease;
  logic        sw_freed, sw_emit;

  always_comb begin
    sw_owner = d_owner;
    sw_lease = d_lease;
    sw_freed = 1'b0;
    if (r_req == REQ_RELEASE) begin
      // free entries the session holds
      if (d_owner == r_sess) begin
        sw_owner = '0;
        sw_freed = 1'b1;
      end
    end else if (d_lease == 16'd1) begin
      // lease runs out: drop the owner
      sw_owner = '0;
      sw_lease = '0;
      sw_freed = 1'b1;
    end else if (d_lease > 16'd1) begin
      sw_lease = d_lease - 16'd1;
    end
    sw_emit = d_valid && sw_freed && (d_owner != 16'd0);
  end

  // Result beat built by the sequencer
  logic        emit;
  logic [1:0]  o_status;
  logic [5:0]  o_addr;
  logic [15:0] o_owner;
  logic        o_last;

  always_comb begin
    state_next   = state;
    ptr_next     = ptr;
    d_valid_next = d_valid;
    d_idx_next   = d_idx;
    mem_we       = 1'b0;
    mem_wa       = d_idx;
    mem_wd       = '0;
    mem_re       = 1'b0;
    mem_ra       = acc_idx;
    emit         = 1'b0;
    o_status     = ST_OK;
    o_addr       = '0;
    o_owner      = '0;
    o_last       = 1'b0;

    unique case (state)
      S_CLEAR: begin
        // zero one entry per cycle
        mem_we = 1'b1;
        mem_wa = ptr[IW-1:0];
        if (ptr == CW'(ENTRIES - 1)) begin
          state_next = S_IDLE;
          ptr_next   = '0;
        end else begin
          ptr_next = ptr + CW'(1);
        end
      end

      S_IDLE: begin
        if (in_accept) begin
          if (is_sweep) begin
            state_next   = S_SWEEP;
            ptr_next     = '0;
            d_valid_next = 1'b0;
          end else begin
            // fetch the addressed entry; unused when the request is refused
            state_next = S_LOOK;
            mem_re     = !addr_bad;
            mem_ra     = acc_idx;
          end
        end
      end

      S_LOOK: begin
        if (out_free) begin
          emit       = 1'b1;
          o_last     = 1'b1;
          o_addr     = r_addr;
          state_next = S_IDLE;
          mem_wa     = IW'(CW'(r_addr) - CW'(1));
          if (r_req > REQ_TICK) begin
            // unknown request type
            o_status = ST_BADADDR;
            o_addr   = '0;
          end else if (r_bad) begin
            o_status = ST_BADADDR;
          end else if (r_req == REQ_QUERY) begin
            o_owner = d_owner;
          end else if ((d_owner != r_sess) && (d_owner != 16'd0)) begin
            o_status = ST_HELD;
            o_owner  = d_owner;
          end else if (r_req == REQ_LOCK) begin
            mem_we  = 1'b1;
            mem_wd  = {r_sess, r_lease};
            o_owner = r_sess;
          end else begin
            // unlock: free the entry and clear its lease
            mem_we = 1'b1;
            mem_wd = '0;
          end
        end
      end

      S_SWEEP: begin
        if (!d_valid && (ptr >= lim)) begin
          // all entries visited: issue the done beat
          if (out_free) begin
            emit       = 1'b1;
            o_last     = 1'b1;
            state_next = S_IDLE;
          end
        end else if (!sw_emit || out_free) begin
          if (d_valid) begin
            mem_we = 1'b1;
            mem_wa = d_idx;
            mem_wd = {sw_owner, sw_lease};
            if (sw_emit) begin
              emit     = 1'b1;
              o_status = ST_RELEASED;
              o_addr   = 6'(CW'(d_idx) + CW'(1));
              o_owner  = d_owner;
            end
          end
          // advance: read the next entry while this one is written back
          if (ptr < lim) begin
            mem_re       = 1'b1;
            mem_ra       = ptr[IW-1:0];
            d_idx_next   = ptr[IW-1:0];
            d_valid_next = 1'b1;
            ptr_next     = ptr + CW'(1);
          end else begin
            d_valid_next = 1'b0;
          end
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      ptr            <= '0;
      d_valid        <= 1'b0;
      active_entries <= 6'd32;
      out_valid      <= 1'b0;
    end else begin
      state   <= state_next;
      ptr     <= ptr_next;
      d_valid <= d_valid_next;
      if (cfg_we) begin
        active_entries <= cfg_wdata;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: request latch, sweep index, result beat
  always_ff @(posedge clk) begin
    d_idx <= d_idx_next;
    if (in_accept) begin
      r_req   <= req_type;
      r_addr  <= address;
      r_sess  <= session;
      r_lease <= lease_ticks;
      r_bad   <= addr_bad;
    end
    if (emit) begin
      status        <= o_status;
      entry_address <= o_addr;
      owner         <= o_owner;
      last          <= o_last;
    end
  end

endmodule

`default_nettype wire

### tb/tb_lease_lock_table.sv
// Self-checking testbench for lease_lock_table: directed and random request beats,
// a mirror of the lock table that predicts every result beat, and a watchdog.
// Depends on lll_pkg and the lease_lock_table RTL only.
`timescale 1ns / 1ps

module tb_lease_lock_table;
  import lll_pkg::*;

  localparam int TABLE_DEPTH    = ENTRIES_DEF;
  // Let a sweep over the whole table finish, with some margin, before touching config.
  localparam int SETTLE_CYCLES  = TABLE_DEPTH + 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 57;
  localparam int MAX_REPORTS    = 10;

  // One result beat as the table should return it.
  typedef struct packed {
    logic [1:0]  st;
    logic [5:0]  addr;
    logic [15:0] own;
    logic        fin;
  } reply_beat_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [5:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  req_type;
  logic [5:0]  address;
  logic [15:0] session;
  logic [15:0] lease_ticks;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [5:0]  entry_address;
  logic [15:0] owner;
  logic        last;

  // Mirror of the lock table, advanced on every accepted request beat.
  logic [15:0] owner_mirror [TABLE_DEPTH];
  logic [15:0] lease_mirror [TABLE_DEPTH];
  logic [5:0]  active_mirror;
  reply_beat_t awaited_replies [$];

  // Stimulus-side bookkeeping.
  logic [5:0]  active_setting;
  logic [15:0] last_locker [64];
  bit          calm;
  int          mismatches;
  int          idle_cycles;

  lease_lock_table dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .address       (address),
    .session       (session),
    .lease_ticks   (lease_ticks),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .entry_address (entry_address),
    .owner         (owner),
    .last          (last)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Stall the result channel with a probability of 28 percent, except in a calm phase.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 28);
  end

  // Queue one expected result beat.
  function automatic void await_reply(input logic [1:0] st, input logic [5:0] ad,
                                      input logic [15:0] ow, input logic fin);
    reply_beat_t b;
    b.st   = st;
    b.addr = ad;
    b.own  = ow;
    b.fin  = fin;
    awaited_replies.push_back(b);
  endfunction

  // Apply one request beat to the mirror and queue the result beats it causes.
  function automatic void apply_table_request(input logic [2:0] rq, input logic [5:0] ad,
                                              input logic [15:0] ss, input logic [15:0] ls);
    int unsigned lim;
    int unsigned i;
    logic [15:0] prev;
    logic        freed;
    lim = (active_mirror > TABLE_DEPTH) ? TABLE_DEPTH : active_mirror;
    if (rq == REQ_RELEASE || rq == REQ_TICK) begin
      // Sweep the active entries in ascending order, one release beat per owned
      // entry that gets freed, then the done beat.
      for (i = 0; i < lim; i++) begin
        prev  = owner_mirror[i];
        freed = 1'b0;
        if (rq == REQ_RELEASE) begin
          if (prev == ss) begin
            owner_mirror[i] = '0;
            freed = 1'b1;
          end
        end else if (lease_mirror[i] == 16'd1) begin
          lease_mirror[i] = '0;
          owner_mirror[i] = '0;
          freed = 1'b1;
        end else if (lease_mirror[i] > 16'd1) begin
          lease_mirror[i] = lease_mirror[i] - 16'd1;
        end
        // A lease of 0 never expires, so it falls through untouched.
        if (freed && prev != 16'd0) await_reply(ST_RELEASED, 6'(i + 1), prev, 1'b0);
      end
      await_reply(ST_OK, '0, '0, 1'b1);
    end else if (rq > REQ_TICK) begin
      // Unknown request codes are refused without looking at the address.
      await_reply(ST_BADADDR, '0, '0, 1'b1);
    end else if (ad == 6'd0 || ad > lim) begin
      await_reply(ST_BADADDR, ad, '0, 1'b1);
    end else begin
      i = ad - 1;
      if (rq == REQ_QUERY) begin
        await_reply(ST_OK, ad, owner_mirror[i], 1'b1);
      end else if (owner_mirror[i] != ss && owner_mirror[i] != 16'd0) begin
        await_reply(ST_HELD, ad, owner_mirror[i], 1'b1);
      end else if (rq == REQ_LOCK) begin
        // A lock by session 0 leaves the entry free but still loads the lease.
        owner_mirror[i] = ss;
        lease_mirror[i] = ls;
        await_reply(ST_OK, ad, ss, 1'b1);
      end else begin
        owner_mirror[i] = '0;
        lease_mirror[i] = '0;
        await_reply(ST_OK, ad, '0, 1'b1);
      end
    end
  endfunction

  // Sample both channels at the rising edge: check result beats against the
  // oldest expectation, then feed accepted request beats into the mirror.
  always @(posedge clk) begin : scoreboard
    reply_beat_t want;
    bit          moved;
    int          k;
    moved = 1'b0;
    if (rst) begin
      for (k = 0; k < TABLE_DEPTH; k++) begin
        owner_mirror[k] = '0;
        lease_mirror[k] = '0;
      end
      active_mirror = 6'd32;
      awaited_replies.delete();
      idle_cycles = 0;
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        moved = 1'b1;
        if (awaited_replies.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: unexpected result beat status=%0d addr=%0d owner=%h last=%b",
                     $realtime, status, entry_address, owner, last);
          mismatches++;
        end else begin
          want = awaited_replies.pop_front();
          if (status !== want.st || entry_address !== want.addr ||
              owner !== want.own || last !== want.fin) begin
            if (mismatches < MAX_REPORTS)
              $display("%0t: result mismatch exp st=%0d addr=%0d own=%h last=%b, got %0d %0d %h %b",
                       $realtime, want.st, want.addr, want.own, want.fin,
                       status, entry_address, owner, last);
            mismatches++;
          end
        end
      end
      if (cfg_we === 1'b1) active_mirror = cfg_wdata;
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        moved = 1'b1;
        apply_table_request(req_type, address, session, lease_ticks);
      end
      // Trip the watchdog when neither channel has moved for too long.
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** lease_lock_table: FAILED **");
        $finish;
      end
    end
  end

  // Drive one request beat and hold it until the table takes it.
  task automatic send_request(input logic [2:0] rq, input logic [5:0] ad,
                              input logic [15:0] ss, input logic [15:0] ls);
    @(negedge clk);
    // Insert random gaps before the beat unless the phase is calm.
    while (!calm && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= rq;
    address     <= ad;
    session     <= ss;
    lease_ticks <= ls;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // Drop valid, wait for every awaited beat, then let the sequencer settle.
  task automatic wait_for_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_active_entries(input logic [5:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    active_setting = value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Bad addresses at both ends, out-of-range addresses and unknown request codes.
  task automatic test_bad_requests();
    send_request(REQ_LOCK,   6'd0,  16'hFFFF, 16'hFFFF);
    send_request(REQ_LOCK,   6'd33, 16'h0001, 16'h0001);
    send_request(REQ_QUERY,  6'd63, 16'h0000, 16'h0000);
    send_request(REQ_UNLOCK, 6'd40, 16'h0002, 16'h0000);
    send_request(3'd5, 6'($urandom), 16'($urandom), 16'($urandom));
    send_request(3'd6, 6'($urandom), 16'($urandom), 16'($urandom));
    send_request(3'd7, 6'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Ownership rules: lock, refused lock and unlock, query, relock by the owner,
  // unlock of a free entry and a lock by session 0.
  task automatic test_lock_ownership();
    send_request(REQ_LOCK,   6'd1, 16'hFFFF, 16'hFFFF);
    send_request(REQ_LOCK,   6'd1, 16'h0001, 16'h0003);
    send_request(REQ_UNLOCK, 6'd1, 16'h0002, 16'h0000);
    send_request(REQ_QUERY,  6'd1, 16'h0000, 16'h0000);
    send_request(REQ_LOCK,   6'd1, 16'hFFFF, 16'h0000);
    send_request(REQ_UNLOCK, 6'd6, 16'h0009, 16'h0000);
    send_request(REQ_LOCK,   6'd2, 16'h0000, 16'h0005);
    send_request(REQ_QUERY,  6'd2, 16'h0007, 16'h0000);
  endtask

  // Lease expiry on 1, countdown above 1, no expiry on 0, and release sweeps
  // including session 0, which frees nothing that has an owner.
  task automatic test_lease_sweeps();
    send_request(REQ_LOCK,    6'd32, 16'h8000, 16'h0001);
    send_request(REQ_LOCK,    6'd3,  16'h0007, 16'h0002);
    send_request(REQ_LOCK,    6'd4,  16'h0007, 16'h0000);
    send_request(REQ_TICK,    6'd0,  16'h0000, 16'h0000);
    send_request(REQ_TICK,    6'd0,  16'h0000, 16'h0000);
    send_request(REQ_RELEASE, 6'd0,  16'h0000, 16'h0000);
    send_request(REQ_RELEASE, 6'd0,  16'h0007, 16'h0000);
    send_request(REQ_RELEASE, 6'd0,  16'hFFFF, 16'h0000);
  endtask

  // Random traffic: mostly valid addresses and a small pool of sessions so that
  // locks collide and short leases expire under frequent ticks; the rest is
  // full-range noise and unknown codes.
  task automatic run_random_items(input int count);
    int unsigned lim;
    int unsigned roll;
    logic [2:0]  rq;
    logic [5:0]  ad;
    logic [15:0] ss;
    logic [15:0] ls;
    lim = (active_setting > TABLE_DEPTH) ? TABLE_DEPTH : active_setting;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 34)      rq = REQ_LOCK;
      else if (roll < 52) rq = REQ_UNLOCK;
      else if (roll < 66) rq = REQ_QUERY;
      else if (roll < 74) rq = REQ_RELEASE;
      else if (roll < 95) rq = REQ_TICK;
      else                rq = 3'($urandom_range(5, 7));

      if (lim > 0 && $urandom_range(0, 99) < 85) ad = 6'($urandom_range(1, lim));
      else ad = 6'($urandom_range(0, 63));

      roll = $urandom_range(0, 99);
      if (roll < 80)      ss = 16'($urandom_range(1, 5));
      else if (roll < 88) ss = 16'h0000;
      else                ss = 16'($urandom);
      // Unlock mostly with the session that last locked the entry.
      if (rq == REQ_UNLOCK && $urandom_range(0, 99) < 60) ss = last_locker[ad];
      if (rq == REQ_LOCK) last_locker[ad] = ss;

      roll = $urandom_range(0, 99);
      if (roll < 70)      ls = 16'($urandom_range(0, 4));
      else if (roll < 80) ls = 16'hFFFF;
      else                ls = 16'($urandom);

      send_request(rq, ad, ss, ls);
    end
  endtask

  // Step through table sizes, extremes and out-of-range values included; run
  // one phase with no idling on either side.
  task automatic test_random_traffic();
    logic [5:0] sizes [8];
    int p;
    sizes = '{6'd5, 6'd0, 6'd1, 6'd63, 6'd33, 6'd0, 6'd32, 6'd17};
    sizes[5] = 6'($urandom_range(2, 31));
    for (p = 0; p < 8; p++) begin
      wait_for_idle();
      write_active_entries(sizes[p]);
      calm = (p == 3);
      run_random_items(PHASE_ITEMS);
    end
    calm = 1'b0;
  endtask

  initial begin
    int k;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    req_type    = '0;
    address     = '0;
    session     = '0;
    lease_ticks = '0;
    out_stall   = 1'b0;
    calm        = 1'b0;
    mismatches  = 0;
    active_setting = 6'd32;
    for (k = 0; k < 64; k++) last_locker[k] = '0;

    // Hold reset, then release it away from the sampling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Let the clearing pass finish before the first config write.
    wait_for_idle();
    write_active_entries(6'd32);

    test_bad_requests();
    test_lock_ownership();
    test_lease_sweeps();
    test_random_traffic();

    wait_for_idle();
    if (mismatches == 0) begin
      $display("** lease_lock_table: PASSED **");
    end else begin
      $display("** lease_lock_table: FAILED **");
    end
    $finish;
  end

endmodule
